@@ src/lhpc_pkg.sv @@
// Lift height preset controller: shared types, widths and codes.
// Used by every module of the block; depends on nothing.
package lhpc_pkg;

   localparam int HEIGHT_BITS = 10;
   localparam int MARGIN_BITS = 8;
   localparam int SUM_BITS    = HEIGHT_BITS + 1;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 4;

   // register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_MIN_HEIGHT     = 2'd0;
   localparam logic [1:0] REG_MAX_HEIGHT     = 2'd1;
   localparam logic [1:0] REG_OVERRUN_MARGIN = 2'd2;

   localparam logic [HEIGHT_BITS-1:0] MAX_HEIGHT_RESET = {HEIGHT_BITS{1'b1}};

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_DOWN = 2'd1,
      MODE_UP   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_STOP = 2'd1,
      CMD_UP   = 2'd2,
      CMD_DOWN = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                   up_hold;
      logic                   down_hold;
      logic                   up_release;
      logic                   down_release;
      logic                   up_single;
      logic                   down_single;
      logic                   up_double;
      logic                   down_double;
      logic [HEIGHT_BITS-1:0] height;
   } req_type;

   typedef struct packed {
      logic [1:0]             motor_cmd;
      logic                   preset_written;
      logic                   preset_slot;
      logic [HEIGHT_BITS-1:0] preset_value;
      logic                   moving_to_preset;
   } rsp_type;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] min_height;
      logic [HEIGHT_BITS-1:0] max_height;
      logic [MARGIN_BITS-1:0] overrun_margin;
   } cfg_type;

   typedef struct packed {
      mode_type mode;
      cmd_type  cmd;
   } step_type;

endpackage

@@ src/lhpc_csr.sv @@
// Lift height preset controller: APB-style configuration registers.
// Depends on lhpc_pkg.
module lhpc_csr import lhpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_HEIGHT:     cfg_in.min_height     = pwdata[HEIGHT_BITS-1:0];
            REG_MAX_HEIGHT:     cfg_in.max_height     = pwdata[HEIGHT_BITS-1:0];
            REG_OVERRUN_MARGIN: cfg_in.overrun_margin = pwdata[MARGIN_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_HEIGHT:
            prdata = {{(DATA_BITS-HEIGHT_BITS){1'b0}}, cfg_ff.min_height};
         REG_MAX_HEIGHT:
            prdata = {{(DATA_BITS-HEIGHT_BITS){1'b0}}, cfg_ff.max_height};
         REG_OVERRUN_MARGIN:
            prdata = {{(DATA_BITS-MARGIN_BITS){1'b0}}, cfg_ff.overrun_margin};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_height     <= '0;
         cfg_ff.max_height     <= MAX_HEIGHT_RESET;
         cfg_ff.overrun_margin <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/lhpc_ctrl.sv @@
// Lift height preset controller: move state, presets and per-update decision.
// Depends on lhpc_pkg; fed from the input register, feeds the result register.
module lhpc_ctrl import lhpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   mode_type               mode_ff, mode_in;
   logic [HEIGHT_BITS-1:0] target_ff, target_in;
   logic [HEIGHT_BITS-1:0] first_ff, first_in;
   logic [HEIGHT_BITS-1:0] second_ff, second_in;

   step_type               move_step, hold_step, step_a, step_b, dec_step;
   logic                   start_a, start_b, in_range, wr_first, wr_second;
   logic [HEIGHT_BITS-1:0] dec_target;

   // one sample of a move in progress
   function automatic step_type drive(mode_type mode, logic [HEIGHT_BITS-1:0] h,
                                      logic [HEIGHT_BITS-1:0] tgt,
                                      logic [MARGIN_BITS-1:0] margin);
      step_type               s;
      logic [SUM_BITS-1:0]    tgt_hi, h_hi;
      tgt_hi = SUM_BITS'(tgt) + SUM_BITS'(margin);
      h_hi   = SUM_BITS'(h) + SUM_BITS'(margin);
      s.mode = MODE_IDLE;
      s.cmd  = CMD_NONE;
      unique case (mode)
         MODE_DOWN: begin
            if (SUM_BITS'(h) > tgt_hi) begin
               s.mode = MODE_DOWN;
               s.cmd  = CMD_DOWN;
            end else begin
               s.cmd  = CMD_STOP;
            end
         end
         MODE_UP: begin
            if (h_hi < SUM_BITS'(tgt)) begin
               s.mode = MODE_UP;
               s.cmd  = CMD_UP;
            end else begin
               s.cmd  = CMD_STOP;
            end
         end
         default: s.cmd = CMD_NONE;
      endcase
      return s;
   endfunction

   // preset move attempt; an unusable preset leaves the command alone
   function automatic step_type try_start(logic [HEIGHT_BITS-1:0] tgt,
                                          logic [HEIGHT_BITS-1:0] h,
                                          cmd_type cmd, cfg_type c);
      step_type s;
      s.mode = MODE_IDLE;
      s.cmd  = cmd;
      if (tgt <= c.max_height && tgt >= c.min_height && h != tgt) begin
         s = drive((h > tgt) ? MODE_DOWN : MODE_UP, h, tgt, c.overrun_margin);
      end
      return s;
   endfunction

   always_comb begin
      move_step = drive(mode_ff, req.height, target_ff, cfg.overrun_margin);

      hold_step.mode = MODE_IDLE;
      hold_step.cmd  = CMD_NONE;
      if (req.up_hold) begin
         hold_step.cmd = (req.height < cfg.max_height) ? CMD_UP : CMD_STOP;
      end
      if (req.down_hold) begin
         hold_step.cmd = (req.height > cfg.min_height) ? CMD_DOWN : CMD_STOP;
      end
      if (req.up_release || req.down_release) begin
         hold_step.cmd = CMD_STOP;
      end

      step_a = hold_step;
      if (req.up_single) begin
         step_a = try_start(first_ff, req.height, hold_step.cmd, cfg);
      end
      start_a = (step_a.mode != MODE_IDLE);

      step_b = step_a;
      if (!start_a && req.down_single) begin
         step_b = try_start(second_ff, req.height, step_a.cmd, cfg);
      end
      start_b = (step_b.mode != MODE_IDLE);

      in_range  = (req.height >= cfg.min_height) && (req.height <= cfg.max_height);
      wr_first  = (mode_ff == MODE_IDLE) && !start_b && in_range && req.up_double;
      wr_second = (mode_ff == MODE_IDLE) && !start_b && in_range && req.down_double;

      if (mode_ff != MODE_IDLE) begin
         dec_step   = move_step;
         dec_target = target_ff;
      end else begin
         dec_step   = step_b;
         dec_target = start_a ? first_ff : (start_b ? second_ff : target_ff);
      end
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      target_in = target_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (fire) begin
         mode_in   = dec_step.mode;
         target_in = dec_target;
         if (wr_first) begin
            first_in = req.height;
         end
         if (wr_second) begin
            second_in = req.height;
         end
      end
   end

   // result of this update
   always_comb begin
      rsp.motor_cmd        = dec_step.cmd;
      rsp.preset_written   = wr_first || wr_second;
      rsp.preset_slot      = wr_second;
      rsp.preset_value     = (wr_first || wr_second) ? req.height : '0;
      rsp.moving_to_preset = (dec_step.mode != MODE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         target_ff <= '0;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

@@ src/lift_height_preset_controller.sv @@
// Lift height preset controller: top level with input and result registers.
// Depends on lhpc_pkg, lhpc_csr and lhpc_ctrl.
//
// Each request transaction is one update (button events plus a height sample)
// and produces exactly one response transaction. An update is registered in
// the input register, is decided from there against the move state and
// presets, and lands in the result register, so a new update is taken every
// cycle while the response side keeps up. The result register holds while a
// response waits in it with rsp_ready low, and the input register holds too
// while it is full; an empty input register still takes a new update.
// Limits and the overrun margin sit in APB registers at byte addresses 0x0
// (min_height), 0x4 (max_height) and 0x8 (overrun_margin); write them only
// while no update is in flight.
module lift_height_preset_controller import lhpc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_free, fire;
   cfg_type cfg;
   rsp_type dec_rsp;

   lhpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lhpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (dec_rsp)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
      if (out_free) begin
         out_valid_in = fire;
         out_data_in  = dec_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
